/* sv/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants of the fixed-point ALU
// Op codes, transaction structs and the pipeline stage record.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  // Fraction bits of the raw fixed-point format
  localparam int unsigned FRAC_BITS = 8;
  // Quotient bits of (|a| << FRAC_BITS) / |b|, one per divider stage
  localparam int unsigned DIV_W = 32 + FRAC_BITS;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               compare_true;
    logic               divide_by_zero;
  } out_t;

  // One pipeline stage: simple results ride along with the divider state
  typedef struct packed {
    logic               valid;
    op_t                op;
    logic [31:0]        value;
    logic               cmp;
    logic               dz;
    logic               neg;
    logic [31:0]        dvs;
    logic [32:0]        rem;
    logic [DIV_W-1:0]   num;
    logic signed [63:0] prod;
  } stg_t;

endpackage

`default_nettype wire

/* sv/fixed_point_alu.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu: pipelined signed 32-bit fixed-point ALU
// Add, subtract, multiply, divide, compare, min/max, increment/decrement and format conversion.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while in_stall is low and returns one result per
// transaction, in order. Every op passes through the same registers: an input
// register, an operand stage with the multiplier, one stage per quotient bit of
// the restoring divider, and the output register. A stall on the output freezes
// the whole pipeline, so in_stall follows out_stall while a result is waiting.
`default_nettype none

module fixed_point_alu (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire fpa_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output fpa_pkg::out_t     out_data
);

  localparam int unsigned F  = fpa_pkg::FRAC_BITS;
  localparam int unsigned DW = fpa_pkg::DIV_W;

  logic          en;
  logic          in_valid_r;
  fpa_pkg::in_t  in_r;
  fpa_pkg::stg_t pre_r;
  fpa_pkg::stg_t pre_nxt;
  fpa_pkg::stg_t chain [0:DW];
  logic          out_valid_r;
  fpa_pkg::out_t out_r;
  fpa_pkg::out_t out_nxt;
  logic          lt;
  logic          eq;
  logic [31:0]   mag_a;
  logic [31:0]   q32;

  // Move everything unless a finished result is held
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Capture input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (en) begin
      in_valid_r <= in_valid;
      in_r       <= in_data;
    end
  end

  // Operand stage: simple ops, product, divider setup
  always_comb begin
    lt    = (in_r.operand_a < in_r.operand_b);
    eq    = (in_r.operand_a == in_r.operand_b);
    mag_a = in_r.operand_a[31] ? (~in_r.operand_a + 32'd1) : in_r.operand_a;
    pre_nxt       = '0;
    pre_nxt.valid = in_valid_r;
    pre_nxt.op    = in_r.op;
    pre_nxt.prod  = 64'(in_r.operand_a) * 64'(in_r.operand_b);
    pre_nxt.neg   = in_r.operand_a[31] ^ in_r.operand_b[31];
    pre_nxt.dvs   = in_r.operand_b[31] ? (~in_r.operand_b + 32'd1) : in_r.operand_b;
    pre_nxt.num   = {mag_a, {F{1'b0}}};
    pre_nxt.rem   = '0;
    unique case (in_r.op)
      fpa_pkg::OP_ADD:      pre_nxt.value = in_r.operand_a + in_r.operand_b;
      fpa_pkg::OP_SUB:      pre_nxt.value = in_r.operand_a - in_r.operand_b;
      fpa_pkg::OP_DIV:      pre_nxt.dz    = (in_r.operand_b == 32'sd0);
      fpa_pkg::OP_GT:       pre_nxt.cmp   = !lt && !eq;
      fpa_pkg::OP_LT:       pre_nxt.cmp   = lt;
      fpa_pkg::OP_GE:       pre_nxt.cmp   = !lt;
      fpa_pkg::OP_LE:       pre_nxt.cmp   = lt || eq;
      fpa_pkg::OP_EQ:       pre_nxt.cmp   = eq;
      fpa_pkg::OP_NE:       pre_nxt.cmp   = !eq;
      fpa_pkg::OP_MIN:      pre_nxt.value = lt ? in_r.operand_a : in_r.operand_b;
      fpa_pkg::OP_MAX:      pre_nxt.value = (!lt && !eq) ? in_r.operand_a
                                                         : in_r.operand_b;
      fpa_pkg::OP_INC:      pre_nxt.value = in_r.operand_a + 32'sd1;
      fpa_pkg::OP_DEC:      pre_nxt.value = in_r.operand_a - 32'sd1;
      fpa_pkg::OP_FROM_INT: pre_nxt.value = in_r.operand_a << F;
      fpa_pkg::OP_TO_INT:   pre_nxt.value = in_r.operand_a >>> F;
      default:              pre_nxt.value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r.valid <= 1'b0;
    end else if (en) begin
      pre_r <= pre_nxt;
    end
  end

  // Divider: one quotient bit per stage
  assign chain[0] = pre_r;

  for (genvar k = 0; k < DW; k++) begin : g_div
    fpa_div_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .stg_i (chain[k]),
      .stg_o (chain[k+1])
    );
  end

  // Final select: product shift, signed quotient or carried value
  always_comb begin
    q32     = chain[DW].num[31:0];
    out_nxt = '0;
    out_nxt.compare_true = chain[DW].cmp;
    case (chain[DW].op)
      fpa_pkg::OP_MUL: out_nxt.value = chain[DW].prod[F+31:F];
      fpa_pkg::OP_DIV: begin
        out_nxt.divide_by_zero = chain[DW].dz;
        if (!chain[DW].dz) begin
          out_nxt.value = chain[DW].neg ? (~q32 + 32'd1) : q32;
        end
      end
      default:         out_nxt.value = chain[DW].value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[DW].valid;
      out_r       <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_by_zero |-> out_data.value == 32'sd0)
    else $error("divide by zero result not zero");

  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.compare_true |-> out_data.value == 32'sd0)
    else $error("compare result carries a value");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.compare_true && out_data.divide_by_zero))
    else $error("compare and divide flags both set");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(chain[DW]) && $stable(pre_r))
    else $error("pipeline moved under stall");
`endif

endmodule

`default_nettype wire

/* sv/fpa_div_stage.sv */
// ----------------------------------------------------------------------------
// fpa_div_stage: one registered restoring-division step
// Shifts one dividend bit into the remainder and one quotient bit out.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_div_stage (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire fpa_pkg::stg_t stg_i,
  output fpa_pkg::stg_t     stg_o
);

  fpa_pkg::stg_t stg_r;
  fpa_pkg::stg_t stg_nxt;
  logic [32:0]   rem_sh;
  logic          ge;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    rem_sh  = {stg_i.rem[31:0], stg_i.num[fpa_pkg::DIV_W-1]};
    ge      = (rem_sh >= {1'b0, stg_i.dvs});
    stg_nxt = stg_i;
    stg_nxt.rem = ge ? (rem_sh - {1'b0, stg_i.dvs}) : rem_sh;
    stg_nxt.num = {stg_i.num[fpa_pkg::DIV_W-2:0], ge};
  end

  // Advance when the pipeline moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.valid <= 1'b0;
    end else if (en) begin
      stg_r <= stg_nxt;
    end
  end

  assign stg_o = stg_r;

endmodule

`default_nettype wire

/* test/fixed_point_alu_test.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu_test: self-checking bench of the fixed-point ALU
// Drives directed and random operations through valid/stall handshakes, with
// idling on both sides, and compares each result with a predicted one in order.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Predicts ALU results and checks them in order
  class alu_scoreboard;
    fpa_pkg::out_t pending[$];
    int            errors;

    function fpa_pkg::out_t compute(fpa_pkg::in_t t);
      fpa_pkg::out_t r;
      logic signed [63:0] wide;
      logic [63:0] ua, ub, q;
      logic signed [31:0] a, b;
      a = t.operand_a;
      b = t.operand_b;
      r = '0;
      case (t.op)
        fpa_pkg::OP_ADD: r.value = a + b;
        fpa_pkg::OP_SUB: r.value = a - b;
        fpa_pkg::OP_MUL: begin
          wide = 64'(a) * 64'(b);
          r.value = 32'(wide >>> fpa_pkg::FRAC_BITS);
        end
        fpa_pkg::OP_DIV: begin
          if (b == 0) begin
            r.divide_by_zero = 1'b1;
          end else begin
            ua = (a < 0 ? -64'(a) : 64'(a)) << fpa_pkg::FRAC_BITS;
            ub = b < 0 ? -64'(b) : 64'(b);
            q = ua / ub;
            if ((a < 0) != (b < 0)) q = -q;
            r.value = q[31:0];
          end
        end
        fpa_pkg::OP_GT: r.compare_true = a > b;
        fpa_pkg::OP_LT: r.compare_true = a < b;
        fpa_pkg::OP_GE: r.compare_true = a >= b;
        fpa_pkg::OP_LE: r.compare_true = a <= b;
        fpa_pkg::OP_EQ: r.compare_true = a == b;
        fpa_pkg::OP_NE: r.compare_true = a != b;
        fpa_pkg::OP_MIN: r.value = (a < b) ? a : b;
        fpa_pkg::OP_MAX: r.value = (a > b) ? a : b;
        fpa_pkg::OP_INC: r.value = a + 1;
        fpa_pkg::OP_DEC: r.value = a - 1;
        fpa_pkg::OP_FROM_INT: r.value = a << fpa_pkg::FRAC_BITS;
        default: r.value = a >>> fpa_pkg::FRAC_BITS;
      endcase
      return r;
    endfunction

    function void note_input(fpa_pkg::in_t t);
      pending.push_back(compute(t));
    endfunction

    function void check_result(fpa_pkg::out_t got);
      fpa_pkg::out_t want;
      if (pending.size() == 0) begin
        $error("unexpected result value=%0d", got.value);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value) begin
        $error("value: expected %0d, got %0d", want.value, got.value);
        errors++;
      end
      if (got.compare_true !== want.compare_true) begin
        $error("compare_true: expected %0b, got %0b", want.compare_true, got.compare_true);
        errors++;
      end
      if (got.divide_by_zero !== want.divide_by_zero) begin
        $error("divide_by_zero: expected %0b, got %0b", want.divide_by_zero,
               got.divide_by_zero);
        errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  fpa_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  fpa_pkg::out_t out_data;

  alu_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  fixed_point_alu u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #2 clk = ~clk;

  // Check each accepted result and pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one transaction, with random idle cycles first, and hold until taken
  task automatic send_op(fpa_pkg::in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    board.note_input(t);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7fff_ffff - $urandom_range(3);
      2: return $urandom_range(8) - 4;
      3: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(int count);
    fpa_pkg::in_t t;
    repeat (count) begin
      t.op = fpa_pkg::op_t'($urandom_range(15));
      t.operand_a = pick_operand();
      t.operand_b = ($urandom_range(15) == 0) ? 32'sd0 : pick_operand();
      send_op(t);
    end
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    fpa_pkg::in_t t;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every op at the extremes, divide by zero, ties and overflow
    for (int k = 0; k < 16; k++) begin
      t.op = fpa_pkg::op_t'(k);
      t.operand_a = 32'sh8000_0000;
      t.operand_b = (k % 2) ? 32'sh7fff_ffff : 32'sh8000_0000;
      send_op(t);
    end
    t = '{fpa_pkg::OP_DIV, 32'sd256, 32'sd0};                  send_op(t);
    t = '{fpa_pkg::OP_DIV, 32'sh7fff_ffff, 32'sd1};            send_op(t);
    t = '{fpa_pkg::OP_DIV, -32'sd300, 32'sd7};                 send_op(t);
    t = '{fpa_pkg::OP_MIN, 32'sd5, 32'sd5};                    send_op(t);
    t = '{fpa_pkg::OP_MAX, -32'sd5, -32'sd5};                  send_op(t);
    t = '{fpa_pkg::OP_TO_INT, -32'sd1, 32'sd0};                send_op(t);
    t = '{fpa_pkg::OP_MUL, 32'sh7fff_ffff, 32'sh7fff_ffff};    send_op(t);
    t = '{fpa_pkg::OP_INC, 32'sh7fff_ffff, -32'sd1};           send_op(t);

    send_random(250);
    send_idle_pct = 67;
    send_random(200);
    send_idle_pct = 0;
    recv_stall_pct = 67;
    send_random(200);
    send_idle_pct = 36;
    recv_stall_pct = 36;
    send_random(200);

    // Hold the output off long enough for the pipeline to fill and back up
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off <= 150;
    send_random(150);
    in_valid <= 1'b0;
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

`default_nettype wire
